FILE: rtl/core/rast_pkg.sv
package rast_pkg;
  localparam int unsigned SUM_W = 26;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 16;

  // item kinds
  localparam logic ACT_ASSIGN = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef enum logic [12:0] {
    ST_CLR   = 13'b0000000000001,
    ST_IDLE  = 13'b0000000000010,
    ST_VISIT = 13'b0000000000100,
    ST_ACC   = 13'b0000000001000,
    ST_PDCHK = 13'b0000000010000,
    ST_PDW1  = 13'b0000000100000,
    ST_PDW2  = 13'b0000001000000,
    ST_PDW3  = 13'b0000010000000,
    ST_CB1   = 13'b0000100000000,
    ST_CB2   = 13'b0001000000000,
    ST_CBW   = 13'b0010000000000,
    ST_RET   = 13'b0100000000000,
    ST_FIN   = 13'b1000000000000
  } state_t;
endpackage

FILE: rtl/core/range_assign_range_sum_tree_core.sv
// Lazy segment tree, range assign / range sum; node state in two RAMs.
// Walk: depth-first, at most four nodes a level; a pending push and a sum
// rebuild add states at a node, an empty range skips the walk, and a result
// can wait on out_ready.
// Throughput: one item in flight. Reset: synchronous rst_n runs a clearing
// pass over all 2*LEAVES entries of both RAMs; no input transfer until it ends.
module range_assign_range_sum_tree_core #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [rast_pkg::IDX_W-1:0]  in_range_low,
  input  logic [rast_pkg::IDX_W-1:0]  in_range_high,
  input  logic [rast_pkg::VAL_W-1:0]  in_assign_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rast_pkg::SUM_W-1:0]  out_range_sum
);
  import rast_pkg::*;

  localparam int unsigned LOG   = $clog2(LEAVES);
  localparam int unsigned NODES = 2 * LEAVES;
  localparam int unsigned PW    = LOG + 1;               // node index width
  localparam int unsigned LW    = $clog2(LOG + 1);       // level width
  localparam int unsigned CW    = ((LOG > IDX_W) ? LOG : IDX_W) + 1;
  // span product, never narrower than a sum
  localparam int unsigned XW    = (VAL_W + LOG > SUM_W) ? VAL_W + LOG : SUM_W;
  localparam int unsigned PDW   = VAL_W + 1;             // {valid, value}

  state_t state_r, state_nxt;

  logic [PW-1:0]    p_r, p_nxt;        // current node
  logic [LW-1:0]    d_r, d_nxt;        // its level, root is 0
  logic             act_r, act_nxt;
  logic [CW-1:0]    a_r, a_nxt, b_r, b_nxt;
  logic [VAL_W-1:0] v_r, v_nxt;        // assign value
  logic [VAL_W-1:0] pv_r, pv_nxt;      // pending value being pushed
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic [SUM_W-1:0] l_r, l_nxt;        // left child sum for combine
  logic [PW-1:0]    clr_r, clr_nxt;
  logic             ov_r, ov_nxt;
  logic [SUM_W-1:0] os_r, os_nxt;

  logic             sum_we, pd_we;
  logic [PW-1:0]    sum_wa, sum_ra, pd_wa, pd_ra;
  logic [SUM_W-1:0] sum_wd, sum_rd;
  logic [PDW-1:0]   pd_wd, pd_rd;

  rast_ram #(.WIDTH(SUM_W), .DEPTH(NODES)) u_sum (
    .clk(clk), .we(sum_we), .wa(sum_wa), .wd(sum_wd), .ra(sum_ra), .rd(sum_rd)
  );
  rast_ram #(.WIDTH(PDW), .DEPTH(NODES)) u_pend (
    .clk(clk), .we(pd_we), .wa(pd_wa), .wd(pd_wd), .ra(pd_ra), .rd(pd_rd)
  );

  // span of current node
  logic [LW-1:0]    sh;
  logic [PW-1:0]    lo_n, hi_n;
  logic [CW-1:0]    lo, hi;
  logic             disjoint, covered, internal;
  logic [XW-1:0]    own_x, kid_x;
  logic [SUM_W-1:0] own_sum, kid_sum;
  logic [PW-1:0]    left_p;
  logic [CW-1:0]    a_in, b_in, b_clip;
  logic             empty_in;

  always_comb begin
    sh       = LW'(LOG) - d_r;
    lo_n     = (p_r ^ (PW'(1) << d_r)) << sh;
    hi_n     = lo_n + ((PW'(1) << sh) - PW'(1));
    lo       = CW'(lo_n);
    hi       = CW'(hi_n);
    disjoint = (b_r < lo) || (hi < a_r);
    covered  = (a_r <= lo) && (hi <= b_r);
    internal = (p_r < PW'(LEAVES));
    // span sizes are powers of two: the multiply is a shift
    own_x    = XW'(v_r) << sh;
    own_sum  = own_x[SUM_W-1:0];
    kid_x    = XW'(pv_r) << (sh - LW'(1));
    kid_sum  = kid_x[SUM_W-1:0];
    left_p   = {p_r[PW-2:0], 1'b0};
    a_in     = CW'(in_range_low);
    b_in     = CW'(in_range_high);
    b_clip   = (b_in > CW'(LEAVES - 1)) ? CW'(LEAVES - 1) : b_in;
    empty_in = (a_in >= CW'(LEAVES)) || (b_clip < a_in);
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = ov_r;
  assign out_range_sum = os_r;

  always_comb begin
    state_nxt = state_r;
    p_nxt = p_r; d_nxt = d_r; act_nxt = act_r; a_nxt = a_r; b_nxt = b_r;
    v_nxt = v_r; pv_nxt = pv_r; acc_nxt = acc_r; l_nxt = l_r; clr_nxt = clr_r;
    ov_nxt = ov_r; os_nxt = os_r;
    sum_we = 1'b0; sum_wa = p_r; sum_wd = '0; sum_ra = p_r;
    pd_we  = 1'b0; pd_wa  = p_r; pd_wd  = '0; pd_ra  = p_r;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        sum_we = 1'b1; sum_wa = clr_r;
        pd_we  = 1'b1; pd_wa  = clr_r;
        clr_nxt = clr_r + PW'(1);
        if (clr_r == PW'(NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt = in_action;
          a_nxt   = a_in;
          b_nxt   = b_clip;
          v_nxt   = in_assign_value;
          acc_nxt = '0;
          p_nxt   = PW'(1);
          d_nxt   = '0;
          if (empty_in) begin
            state_nxt = (in_action == ACT_QUERY) ? ST_FIN : ST_IDLE;
          end else begin
            state_nxt = ST_VISIT;
          end
        end
      end
      ST_VISIT: begin
        // both RAMs are read at p here; data lands next cycle
        if (disjoint) begin
          state_nxt = ST_RET;
        end else if (covered) begin
          if (act_r == ACT_ASSIGN) begin
            sum_we = 1'b1; sum_wd = own_sum;
            pd_we  = internal;
            pd_wd  = {1'b1, v_r};
            state_nxt = ST_RET;
          end else begin
            state_nxt = ST_ACC;
          end
        end else begin
          state_nxt = ST_PDCHK;
        end
      end
      ST_ACC: begin
        acc_nxt   = acc_r + sum_rd;
        state_nxt = ST_RET;
      end
      ST_PDCHK: begin
        pv_nxt = pd_rd[VAL_W-1:0];
        if (pd_rd[VAL_W]) begin
          state_nxt = ST_PDW1;
        end else begin
          p_nxt = left_p; d_nxt = d_r + LW'(1);
          state_nxt = ST_VISIT;
        end
      end
      ST_PDW1: begin
        sum_we = 1'b1; sum_wa = left_p; sum_wd = kid_sum;
        pd_we  = 1'b1; pd_wa  = left_p; pd_wd  = {1'b1, pv_r};
        state_nxt = ST_PDW2;
      end
      ST_PDW2: begin
        sum_we = 1'b1; sum_wa = left_p | PW'(1); sum_wd = kid_sum;
        pd_we  = 1'b1; pd_wa  = left_p | PW'(1); pd_wd  = {1'b1, pv_r};
        state_nxt = ST_PDW3;
      end
      ST_PDW3: begin
        pd_we = 1'b1; pd_wd = '0;
        p_nxt = left_p; d_nxt = d_r + LW'(1);
        state_nxt = ST_VISIT;
      end
      ST_CB1: begin
        sum_ra = left_p;
        state_nxt = ST_CB2;
      end
      ST_CB2: begin
        sum_ra = left_p | PW'(1);
        l_nxt  = sum_rd;
        state_nxt = ST_CBW;
      end
      ST_CBW: begin
        sum_we = 1'b1; sum_wd = l_r + sum_rd;
        state_nxt = ST_RET;
      end
      ST_RET: begin
        // climb: left child moves to sibling, right child closes the parent
        if (d_r == '0) begin
          state_nxt = (act_r == ACT_QUERY) ? ST_FIN : ST_IDLE;
        end else if (!p_r[0]) begin
          p_nxt = p_r | PW'(1);
          state_nxt = ST_VISIT;
        end else begin
          p_nxt = p_r >> 1; d_nxt = d_r - LW'(1);
          state_nxt = (act_r == ACT_QUERY) ? ST_RET : ST_CB1;
        end
      end
      ST_FIN: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          os_nxt = acc_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
    p_r <= p_nxt; d_r <= d_nxt; act_r <= act_nxt; a_r <= a_nxt; b_r <= b_nxt;
    v_r <= v_nxt; pv_r <= pv_nxt; acc_r <= acc_nxt; l_r <= l_nxt; os_r <= os_nxt;
  end
endmodule

FILE: rtl/core/rast_ram.sv
module rast_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end
endmodule

FILE: sim/rast_checker.sv
`timescale 1ns / 100ps

module rast_checker #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_action,
  input  logic [rast_pkg::IDX_W-1:0]  in_range_low,
  input  logic [rast_pkg::IDX_W-1:0]  in_range_high,
  input  logic [rast_pkg::VAL_W-1:0]  in_assign_value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [rast_pkg::SUM_W-1:0]  out_range_sum,
  output int                          fail_count,
  output int                          sums_pending
);
  import rast_pkg::*;

  // flat leaf mirror; lazy structure is invisible from outside
  logic [VAL_W-1:0] leaf_val [LEAVES];
  logic [SUM_W-1:0] sum_queue [$];

  function automatic logic [SUM_W-1:0] leaf_sum(int lo, int hi);
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (int i = lo; i <= hi; i++) acc += SUM_W'(leaf_val[i]);
    return acc;
  endfunction

  always @(posedge clk) begin
    int lo, hi;
    logic [SUM_W-1:0] want;
    if (!rst_n) begin
      foreach (leaf_val[i]) leaf_val[i] = '0;
      sum_queue.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (sum_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected sum %0d", out_range_sum);
        end else begin
          want = sum_queue.pop_front();
          if (want !== out_range_sum) begin
            fail_count++;
            if (fail_count <= 10)
              $display("sum mismatch: exp %0d got %0d", want, out_range_sum);
          end
        end
      end
      if (in_valid && in_ready) begin
        lo = in_range_low;
        hi = (in_range_high > LEAVES - 1) ? LEAVES - 1 : in_range_high;
        if (in_action == ACT_QUERY) begin
          want = (lo >= LEAVES || hi < lo) ? '0 : leaf_sum(lo, hi);
          sum_queue = {sum_queue, want};
        end else if (!(lo >= LEAVES || hi < lo)) begin
          for (int i = lo; i <= hi; i++) leaf_val[i] = in_assign_value;
        end
      end
    end
    sums_pending = sum_queue.size();
  end
endmodule

FILE: sim/range_assign_range_sum_tree_core_tb.sv
`timescale 1ns / 100ps

module range_assign_range_sum_tree_core_tb;
  import rast_pkg::*;

  localparam int unsigned LEAVES = 1024;
  localparam int N_RANDOM = 1350;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic [IDX_W-1:0] in_range_low = '0;
  logic [IDX_W-1:0] in_range_high = '0;
  logic [VAL_W-1:0] in_assign_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SUM_W-1:0] out_range_sum;
  int fail_count;
  int sums_pending;
  bit quiet_phase = 1'b0; // last stretch: no idling either side
  bit hold_sink = 1'b0;   // long receiver hold-off

  range_assign_range_sum_tree_core #(.LEAVES(LEAVES)) u_top (.*);

  rast_checker #(.LEAVES(LEAVES)) u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_range_low,
    .in_range_high, .in_assign_value, .out_valid, .out_ready, .out_range_sum,
    .fail_count, .sums_pending
  );

  initial forever #6 clk = ~clk;

  // watchdog: ~1400 items plus stalls, many times over
  initial begin
    #(12 * 3_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_sink) out_ready <= 1'b0;
      else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 17);
        repeat (n - 1) @(posedge clk);
      end else out_ready <= 1'b1;
    end
  end

  // one transfer on the input channel, with optional idle burst first;
  // valid stays up after the transfer until the next item or release_input
  task automatic send_item(logic act, int lo, int hi, int val);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_range_low <= IDX_W'(lo);
    in_range_high <= IDX_W'(hi);
    in_assign_value <= VAL_W'(val);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (sums_pending != 0) @(posedge clk);
  endtask

  task automatic random_item();
    int lo, hi, r, span;
    r = $urandom_range(0, 9);
    lo = $urandom_range(0, LEAVES - 1);
    span = $urandom_range(0, 64);
    // mostly narrow or ordered ranges, sometimes wide, reversed or edge
    case (r)
      0: hi = $urandom_range(0, LEAVES - 1);
      1: begin lo = 0; hi = LEAVES - 1; end
      2: hi = lo;
      default: hi = (lo + span > LEAVES - 1) ? LEAVES - 1 : lo + span;
    endcase
    send_item(1'($urandom_range(0, 1)), lo, hi, $urandom_range(0, 65535));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty tree, extremes, reversed ranges, full span, leaves
    send_item(ACT_QUERY,  0, LEAVES - 1, 0);
    send_item(ACT_ASSIGN, 0, LEAVES - 1, 16'hFFFF);
    send_item(ACT_QUERY,  0, LEAVES - 1, 0);
    send_item(ACT_QUERY,  LEAVES - 1, LEAVES - 1, 16'hFFFF);
    send_item(ACT_ASSIGN, 5, 3, 16'h1234);   // reversed: no effect
    send_item(ACT_QUERY,  9, 2, 0);          // reversed: zero
    send_item(ACT_ASSIGN, 0, 0, 0);
    send_item(ACT_QUERY,  0, 1, 0);
    send_item(ACT_ASSIGN, 1, 1022, 16'h5555);
    send_item(ACT_QUERY,  0, 511, 0);
    send_item(ACT_QUERY,  512, LEAVES - 1, 0);
    send_item(ACT_ASSIGN, 300, 700, 16'hAAAA);
    send_item(ACT_QUERY,  299, 701, 0);
    send_item(ACT_QUERY,  511, 512, 0);
    send_item(ACT_ASSIGN, 511, 512, 1);
    send_item(ACT_QUERY,  0, LEAVES - 1, 0);
    release_input();
    wait_drained();

    // long receiver hold-off while items keep coming
    hold_sink = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_sink = 1'b0;
      end
      begin
        repeat (20) random_item();
        release_input();
      end
    join
    wait_drained(); // sender pauses until all sums are back

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 150) quiet_phase = 1'b1;
      random_item();
    end
    release_input();
    wait_drained();
    repeat (200) @(posedge clk);

    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
